// File: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Concurrent properties are compiled only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication check: antecedent |-> consequent on every rising clock edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold on a rising clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/bsb_pkg.sv
// Shared types and constants for the B-spline to Bezier stream core.
// No dependencies; imported by every module of the core.
package bsb_pkg;

    localparam int COORD_W  = 32;
    localparam int NUM_AXES = 3;
    localparam int TDATA_W  = NUM_AXES * COORD_W;

    // Sum of up to six coordinates, signed.
    localparam int SUM_W = COORD_W + 3;
    // Rounded magnitude fed to the divide-by-3 unit.
    localparam int N_W   = COORD_W + 2;

    // floor(n / 3) = (n * RECIP) >> RECIP_SHIFT, exact for n < 2**N_W
    localparam int RECIP_SHIFT = N_W + 2;
    localparam int RECIP_W     = N_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((128'd1 << RECIP_SHIFT) / 3) + 128'd1);
    localparam int REC_LO_W = RECIP_W / 2;
    localparam int REC_HI_W = RECIP_W - REC_LO_W;
    localparam logic [REC_LO_W-1:0] RECIP_LO = RECIP[REC_LO_W-1:0];
    localparam logic [REC_HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:REC_LO_W];
    localparam int PP_LO_W = N_W + REC_LO_W;
    localparam int PP_HI_W = N_W + REC_HI_W;
    localparam int TOT_W   = N_W + RECIP_W;

    // Half divisor added before truncation (round half away from zero).
    localparam logic [N_W-1:0] RND_DIV3 = N_W'(1);
    localparam logic [N_W-1:0] RND_DIV6 = N_W'(3);

    // Points held per curve before segments are produced.
    localparam logic [1:0] FULL_COUNT = 2'd3;

    typedef logic [COORD_W-1:0]               coord_t;
    typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_t;
    typedef logic [SUM_W-1:0]                 sum_t;
    typedef logic [NUM_AXES-1:0][SUM_W-1:0]   sum_vec_t;

    // Work handed from the window to the sequencer for one input point.
    typedef struct packed {
        logic   has_result;
        logic   first;
        logic   too_few;
        point_t d0;
        point_t d1;
        point_t d2;
        point_t d3;
    } job_t;

    // Sideband that travels with each result through the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic too_few;
    } ctl_t;

    typedef struct packed {
        logic busy;
        logic finishing;
    } seq_stat_t;

endpackage

// File: rtl/core/bspline_to_bezier_stream_core.sv
// Uniform cubic B-spline to Bezier stream converter, top level.
// Input point stream in, Bezier point stream out (one point per transaction).
// The first result of an input point reaches m_tvalid through the sequencer's
// job registers, the sum register, the divider and the output register.
// Throughput: a point that yields no result (first three of a curve) is
// taken every cycle unless the sequencer holds a pending segment or the output stalls.
// A point that yields results occupies the sequencer until its last result is
// issued: 4 results for the first segment of a curve, 3 for each later one,
// 1 for a short-curve marker, at one weighted sum per cycle unless stalled.
// s_tlast marks the last control point of a curve; a curve of fewer than four
// points yields one result with m_tuser high and zero coordinates.
// m_tlast marks the final result caused by one input point.
// Reset clears the point count and empties the pipeline; held points are not
// cleared. While a result waits on m_tready the whole pipeline holds and
// s_tready drops, as it does as soon as the sequencer cannot take a new segment.
// Depends on bsb_pkg, bsb_window, bsb_seq, bsb_div and assert_macros.svh.
`include "assert_macros.svh"

module bspline_to_bezier_stream_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bsb_pkg::TDATA_W-1:0] s_tdata,   // point_x, point_y, point_z
    input  logic                        s_tlast,   // end_of_curve
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bsb_pkg::TDATA_W-1:0] m_tdata,   // bez_x, bez_y, bez_z
    output logic                        m_tlast,   // last_of_run
    output logic                        m_tuser    // too_few
);
    import bsb_pkg::*;

    logic      adv;
    logic      accept;
    point_t    point;
    job_t      job;
    seq_stat_t stat;
    ctl_t      ctl1;
    sum_vec_t  sums;
    logic      div6;
    ctl_t      ctl2_reg;
    ctl_t      ctl3_reg;
    ctl_t      out_ctl_reg;
    point_t    quot;
    point_t    out_data_reg;

    assign adv    = !out_ctl_reg.valid || m_tready;
    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            point[a] = s_tdata[a*COORD_W +: COORD_W];
        end
    end

    bsb_window u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .point        (point),
        .end_of_curve (s_tlast),
        .job          (job)
    );

    bsb_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .accept   (accept),
        .job      (job),
        .in_ready (s_tready),
        .stat     (stat),
        .ctl      (ctl1),
        .sums     (sums),
        .div6     (div6)
    );

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        bsb_div u_div
        (
            .clk  (clk),
            .en   (adv),
            .sum  (sums[a]),
            .div6 (div6),
            .quot (quot[a])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg    <= '0;
            ctl3_reg    <= '0;
            out_ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl2_reg    <= ctl1;
            ctl3_reg    <= ctl2_reg;
            out_ctl_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= ctl3_reg.too_few ? '0 : quot;
        end
    end

    assign m_tvalid = out_ctl_reg.valid;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_ctl_reg.last;
    assign m_tuser  = out_ctl_reg.too_few;

    // a new point is taken only when the sequencer is free or on its last result
    `ASSERT_IMPLIES(a_ready_when_free, clk, rst_n, s_tready, !stat.busy || stat.finishing, "input taken while segment pending")
    // short-curve marker is always a single, final result
    `ASSERT_IMPLIES(a_few_is_last, clk, rst_n, m_tvalid && m_tuser, m_tlast, "too_few result not last of run")
    `ASSERT_IMPLIES(a_few_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0, "too_few result with nonzero data")
    // no input point is taken while the output is stalled
    `ASSERT_NEVER(a_no_accept_stalled, clk, rst_n, accept && m_tvalid && !m_tready, "input taken during output stall")

endmodule

// File: rtl/core/bsb_window.sv
// Control point window: last three points, point count and joint flag.
// Depends on bsb_pkg.
module bsb_window
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  bsb_pkg::point_t point,
    input  logic            end_of_curve,
    output bsb_pkg::job_t   job
);
    import bsb_pkg::*;

    point_t     w0_reg;
    point_t     w1_reg;
    point_t     w2_reg;
    logic [1:0] seen_reg;
    logic [1:0] seen_next;
    logic       joint_reg;
    logic       joint_next;

    always_comb
    begin
        job.has_result = end_of_curve || (seen_reg == FULL_COUNT);
        job.first      = !joint_reg;
        job.too_few    = (seen_reg != FULL_COUNT);
        job.d0         = w0_reg;
        job.d1         = w1_reg;
        job.d2         = w2_reg;
        job.d3         = point;
    end

    always_comb
    begin
        seen_next  = seen_reg;
        joint_next = joint_reg;
        if (accept)
        begin
            if (end_of_curve)
            begin
                seen_next  = 2'd0;
                joint_next = 1'b0;
            end
            else if (seen_reg == FULL_COUNT)
            begin
                joint_next = 1'b1;
            end
            else
            begin
                seen_next = seen_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 2'd0;
            joint_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            joint_reg <= joint_next;
        end
    end

    // Window shifts on every accepted point, oldest first.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= point;
        end
    end

endmodule

// File: rtl/core/bsb_seq.sv
// Sequencer: holds one segment job, issues one weighted sum per unstalled cycle.
// Depends on bsb_pkg.
module bsb_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               accept,
    input  bsb_pkg::job_t      job,
    output logic               in_ready,
    output bsb_pkg::seq_stat_t stat,
    output bsb_pkg::ctl_t      ctl,
    output bsb_pkg::sum_vec_t  sums,
    output logic               div6
);
    import bsb_pkg::*;

    localparam logic [1:0] SEG_P0 = 2'd0;
    localparam logic [1:0] SEG_P1 = 2'd1;
    localparam logic [1:0] SEG_P2 = 2'd2;
    localparam logic [1:0] SEG_P3 = 2'd3;

    logic       busy_reg;
    logic       busy_next;
    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic       few_reg;
    logic       few_next;
    logic       finishing;
    logic       load_job;
    point_t     jd0_reg;
    point_t     jd1_reg;
    point_t     jd2_reg;
    point_t     jd3_reg;
    ctl_t       ctl_reg;
    sum_vec_t   sums_reg;
    sum_vec_t   sums_next;
    logic       div6_reg;

    function automatic sum_t ext(input coord_t c);
        ext = {{(SUM_W - COORD_W){c[COORD_W-1]}}, c};
    endfunction

    function automatic sum_t seg_sum(input logic [1:0] k, input coord_t c0, input coord_t c1,
                                     input coord_t c2, input coord_t c3);
        sum_t e0;
        sum_t e1;
        sum_t e2;
        sum_t e3;
        e0 = ext(c0);
        e1 = ext(c1);
        e2 = ext(c2);
        e3 = ext(c3);
        case (k)
            SEG_P0:  seg_sum = e0 + (e1 << 2) + e2;
            SEG_P1:  seg_sum = (e1 << 1) + e2;
            SEG_P2:  seg_sum = e1 + (e2 << 1);
            SEG_P3:  seg_sum = e1 + (e2 << 2) + e3;
            default: seg_sum = '0;
        endcase
    endfunction

    assign finishing = busy_reg && (k_reg == SEG_P3);
    assign in_ready  = adv && (!busy_reg || finishing);
    assign load_job  = adv && accept && job.has_result;

    assign stat.busy      = busy_reg;
    assign stat.finishing = finishing;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        few_next  = few_reg;
        if (load_job)
        begin
            busy_next = 1'b1;
            few_next  = job.too_few;
            // a short curve gives a single flagged result
            if (job.too_few)
                k_next = SEG_P3;
            else if (job.first)
                k_next = SEG_P0;
            else
                k_next = SEG_P1;
        end
        else if (adv)
        begin
            if (finishing)
                busy_next = 1'b0;
            else if (busy_reg)
                k_next = k_reg + 2'd1;
        end
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sums_next[a] = seg_sum(k_reg, jd0_reg[a], jd1_reg[a], jd2_reg[a], jd3_reg[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= SEG_P0;
            few_reg  <= 1'b0;
            ctl_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            few_reg  <= few_next;
            if (adv)
            begin
                ctl_reg.valid   <= busy_reg;
                ctl_reg.last    <= finishing;
                ctl_reg.too_few <= few_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_job)
        begin
            jd0_reg <= job.d0;
            jd1_reg <= job.d1;
            jd2_reg <= job.d2;
            jd3_reg <= job.d3;
        end
        if (adv)
        begin
            sums_reg <= sums_next;
            div6_reg <= (k_reg == SEG_P0) || (k_reg == SEG_P3);
        end
    end

    assign ctl  = ctl_reg;
    assign sums = sums_reg;
    assign div6 = div6_reg;

endmodule

// File: rtl/core/bsb_div.sv
// Rounded signed divide by 3 or 6 of one coordinate sum, two register stages.
// Reciprocal multiply split into two partial products. Depends on bsb_pkg.
module bsb_div
(
    input  logic            clk,
    input  logic            en,
    input  bsb_pkg::sum_t   sum,
    input  logic            div6,
    output bsb_pkg::coord_t quot
);
    import bsb_pkg::*;

    logic               neg;
    sum_t               mag;
    logic [N_W-1:0]     rnd_sum;
    logic [N_W-1:0]     n_next;
    logic [N_W-1:0]     n_reg;
    logic               neg_a_reg;
    logic               neg_b_reg;
    logic [PP_LO_W-1:0] pp_lo_reg;
    logic [PP_HI_W-1:0] pp_hi_reg;
    logic [TOT_W-1:0]   total;
    coord_t             q;

    // magnitude plus half divisor; n/6 is taken as (n/2)/3
    always_comb
    begin
        neg     = sum[SUM_W-1];
        mag     = neg ? (~sum + 1'b1) : sum;
        rnd_sum = mag[N_W-1:0] + (div6 ? RND_DIV6 : RND_DIV3);
        n_next  = div6 ? (rnd_sum >> 1) : rnd_sum;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg     <= n_next;
            neg_a_reg <= neg;
            pp_lo_reg <= PP_LO_W'(n_reg) * PP_LO_W'(RECIP_LO);
            pp_hi_reg <= PP_HI_W'(n_reg) * PP_HI_W'(RECIP_HI);
            neg_b_reg <= neg_a_reg;
        end
    end

    always_comb
    begin
        total = (TOT_W'(pp_hi_reg) << REC_LO_W) + TOT_W'(pp_lo_reg);
        q     = total[RECIP_SHIFT +: COORD_W];
        quot  = neg_b_reg ? (~q + 1'b1) : q;
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bspline_to_bezier_stream_core: streams control-point curves in,
// predicts the Bezier points in a scoreboard class and checks every output transaction.
// Depends on bsb_pkg and the core RTL; reads no files.
module tb;
    import bsb_pkg::*;

    localparam coord_t CMAX           = 32'h7fff_ffff;
    localparam coord_t CMIN           = 32'h8000_0000;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     HOLD_CYCLES    = 300;
    localparam int     TAIL_CYCLES    = 12;

    class bezier_scoreboard;
        typedef struct {
            point_t pt;
            bit     last;
            bit     few;
        } bez_point_t;

        bez_point_t expected_q[$];
        point_t     win[3];
        bit [1:0]   held;
        bit         joint_done;
        int         mismatches;

        // (wa*a + wb*b + wc*c) / div per axis, rounded half away from zero
        function automatic point_t blend(point_t a, int wa, point_t b, int wb,
                                         point_t c, int wc, int div);
            point_t r;
            longint acc;
            longint mag;
            longint q;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                acc = wa * longint'($signed(a[k])) + wb * longint'($signed(b[k]))
                    + wc * longint'($signed(c[k]));
                mag = (acc < 0) ? -acc : acc;
                q   = (mag + div / 2) / div;
                if (acc < 0)
                    q = -q;
                r[k] = coord_t'(q);
            end
            return r;
        endfunction

        function void push(point_t pt, bit last, bit few);
            bez_point_t e;
            e.pt   = pt;
            e.last = last;
            e.few  = few;
            expected_q.push_back(e);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Called once per accepted input transaction.
        function void take_point(point_t p, bit eoc);
            if (held < FULL_COUNT)
            begin
                win[0] = win[1];
                win[1] = win[2];
                win[2] = p;
                held++;
                if (eoc)
                begin
                    push('0, 1'b1, 1'b1);
                    held       = 0;
                    joint_done = 0;
                end
                return;
            end
            // joint point goes out only with the first segment of a curve
            if (!joint_done)
                push(blend(win[0], 1, win[1], 4, win[2], 1, 6), 1'b0, 1'b0);
            push(blend(win[1], 2, win[2], 1, '0, 0, 3), 1'b0, 1'b0);
            push(blend(win[1], 1, win[2], 2, '0, 0, 3), 1'b0, 1'b0);
            push(blend(win[1], 1, win[2], 4, p, 1, 6), 1'b1, 1'b0);
            win[0]     = win[1];
            win[1]     = win[2];
            win[2]     = p;
            joint_done = !eoc;
            if (eoc)
                held = 0;
        endfunction

        task report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
            $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_bezier(point_t got, logic last, logic few);
            bez_point_t e;
            if (expected_q.size() == 0)
            begin
                report_mismatch("output transaction with nothing pending", got[0], '0);
                return;
            end
            e = expected_q.pop_front();
            for (int k = 0; k < NUM_AXES; k++)
                if (got[k] !== e.pt[k])
                    report_mismatch($sformatf("bez axis %0d", k), got[k], e.pt[k]);
            if (last !== e.last)
                report_mismatch("m_tlast", COORD_W'(last), COORD_W'(e.last));
            if (few !== e.few)
                report_mismatch("m_tuser", COORD_W'(few), COORD_W'(e.few));
        endtask
    endclass

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;
    logic               m_tuser;

    bezier_scoreboard sb;
    bit               idle_on  = 1'b1;
    bit               hold_req = 1'b0;
    int               n_sent   = 0;
    int               stall_cycles = 0;

    bspline_to_bezier_stream_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic point_t mk(coord_t x, coord_t y, coord_t z);
        return {z, y, x};
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0:       return CMAX;
            1:       return CMIN;
            2, 3, 4: return coord_t'(int'($urandom_range(0, 24)) - 12);
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed curves; short ones end before the first segment
    function automatic int curve_len();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(1, 3);
            2:       return $urandom_range(11, 16);
            default: return $urandom_range(4, 10);
        endcase
    endfunction

    task automatic send_point(point_t p, bit eoc);
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tlast  <= eoc;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_point(p, eoc);
        n_sent++;
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_curve(int len, bit with_gaps);
        for (int i = 0; i < len; i++)
        begin
            send_point(mk(rand_coord(), rand_coord(), rand_coord()), i == len - 1);
            if (with_gaps)
                sender_gap();
        end
    endtask

    task automatic random_curves(int upto);
        while (n_sent < upto)
            send_curve(curve_len(), 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // receiver: random backpressure, one long hold on request
    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (idle_on ? $urandom_range(1, 20) : 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_bezier(m_tdata, m_tlast, m_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
                     $realtime, stall_cycles, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short curves of one, two and three points
        send_point(mk(CMAX, CMIN, CMAX), 1'b1);
        send_point(mk(1, 2, 3), 1'b0);
        send_point(mk(CMIN, CMAX, 0), 1'b1);
        send_point(mk(-1, -1, -1), 1'b0);
        send_point(mk(CMAX, CMAX, CMAX), 1'b0);
        send_point(mk(CMIN, CMIN, CMIN), 1'b1);
        // full-scale positive curve, then a swing to full-scale negative
        repeat (4) send_point(mk(CMAX, CMAX, CMAX), 1'b0);
        send_point(mk(CMIN, CMIN, CMIN), 1'b1);
        // exact halves: rounding ties on both signs
        send_point(mk(3, -3, 9), 1'b0);
        send_point(mk(0, 0, 0), 1'b0);
        send_point(mk(0, 0, 0), 1'b0);
        send_point(mk(-3, 3, -9), 1'b1);
        // alternating extremes
        for (int i = 0; i < 6; i++)
            send_point(i[0] ? mk(CMAX, CMIN, CMAX) : mk(CMIN, CMAX, CMIN), i == 5);

        random_curves(75);

        // output stalled for a long stretch while input keeps coming
        hold_req = 1'b1;
        send_curve(14, 1'b0);
        drain();

        random_curves(105);

        idle_on = 1'b0;
        random_curves(130);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// File: bspline_to_bezier_stream_core.f
+incdir+rtl/core
rtl/core/bsb_pkg.sv
rtl/core/bsb_window.sv
rtl/core/bsb_seq.sv
rtl/core/bsb_div.sv
rtl/core/bspline_to_bezier_stream_core.sv
dv/tb.sv
